/* src/round_robin_time_slice_scheduler_core_defines.svh */
// Assertion macros shared by the scheduler RTL.
// Each macro expects clk and rst_n to exist in the scope where it is used.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define RRTSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Invariant that must hold at every clock edge out of reset.
`define RRTSS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("scheduler invariant failed");

`endif

/* src/rrtss_pkg.sv */
`default_nettype none

package rrtss_pkg;

  // Fixed field widths of the transaction ports.
  localparam int TAG_W     = 4;
  localparam int IN_REM_W  = 16;
  localparam int OUT_REM_W = 16;
  localparam int SLICE_W   = 8;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd4;
  localparam logic [SLICE_W-1:0] SLICE_MIN   = 8'd1;

  typedef enum logic {
    REQ_ARRIVAL = 1'b0,
    REQ_TICK    = 1'b1
  } req_e_t;

  // Requests from the scheduler to the ready ring.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  // Status returned by the ready ring for the current cycle.
  typedef struct packed {
    logic push_ok;
    logic pop_ok;
  } ring_stat_t;

endpackage

`default_nettype wire

/* src/rrtss_ring.sv */
`default_nettype none

// Ready ring: a FIFO of task entries. A push and a pop may happen in the same
// cycle; the pop then sees the pushed entry when the ring was empty. The entry
// at the head is kept in a register, so the array is only read on a clock edge.
module rrtss_ring
  import rrtss_pkg::*;
#(
  parameter int DEPTH   = 16,
  parameter int ENTRY_W = 20,
  parameter int CNT_W   = 5,
  parameter int IDX_W   = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ring_ctrl_t         ctrl,
  input  wire logic [ENTRY_W-1:0] push_data,
  output logic      [ENTRY_W-1:0] pop_data,
  output ring_stat_t              stat,
  output logic      [CNT_W-1:0]   count,
  output logic      [CNT_W-1:0]   count_nxt
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] head_data_r;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   cnt_pushed;
  logic               push_ok;
  logic               pop_ok;

  assign push_ok    = ctrl.push && (count_r < CNT_W'(DEPTH));
  assign cnt_pushed = count_r + CNT_W'(push_ok);
  assign pop_ok     = ctrl.pop && (cnt_pushed != '0);
  assign count_nxt  = cnt_pushed - CNT_W'(pop_ok);
  assign count      = count_r;

  // An empty ring can only deliver the entry being pushed this cycle.
  assign pop_data = (count_r == '0) ? push_data : head_data_r;

  assign head_nxt = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_nxt = (tail_r == IDX_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;

  assign stat.push_ok = push_ok;
  assign stat.pop_ok  = pop_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push_ok) begin
        tail_r <= tail_nxt;
      end
      if (pop_ok) begin
        head_r <= head_nxt;
      end
      count_r <= count_nxt;
    end
  end

  // The head register follows the entry that will be at the head next cycle:
  // after a pop it is the following slot, unless that slot is written now.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail_r] <= push_data;
    end
    if (pop_ok) begin
      if (push_ok && (tail_r == head_nxt)) begin
        head_data_r <= push_data;
      end else begin
        head_data_r <= mem[head_nxt];
      end
    end else if (push_ok && (count_r == '0)) begin
      head_data_r <= push_data;
    end
  end

endmodule

`default_nettype wire

/* src/round_robin_time_slice_scheduler_core.sv */
// A taken transaction passes the input and result registers, then shows a one-cycle out_valid.
// Throughput: one transaction per cycle; busy is never raised and the receiver cannot stall.
// The rate is set by the single update path from the input register to the result register.
// Reset (rst_n low, synchronous) empties the ring, drops the running and preempted tasks,
// and sets the quantum to four ticks; ring entries themselves are not cleared.
`default_nettype none
`include "round_robin_time_slice_scheduler_core_defines.svh"

module round_robin_time_slice_scheduler_core
  import rrtss_pkg::*;
#(
  parameter int RING_DEPTH = 16,
  parameter int BURST_BITS = 16,
  localparam int CNT_W     = $clog2(RING_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input transaction channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_req_type,
  input  wire logic [TAG_W-1:0]     in_task_tag,
  input  wire logic [IN_REM_W-1:0]  in_burst_length,
  // Configuration register (time quantum)
  input  wire logic                 cfg_we,
  input  wire logic [SLICE_W-1:0]   cfg_wdata,
  // Result transaction channel
  output logic                      out_valid,
  output logic                      out_arrival_accepted,
  output logic                      out_cpu_busy,
  output logic [TAG_W-1:0]          out_run_tag,
  output logic [OUT_REM_W-1:0]      out_run_remaining,
  output logic                      out_task_done,
  output logic                      out_slice_end,
  output logic [CNT_W-1:0]          out_queued_count
);

  localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int ENTRY_W = TAG_W + BURST_BITS;
  localparam int OCC_W   = CNT_W + 1;

  // ---------------------------------------------------------------------------
  // Input register. Every start is taken, so the register simply samples the
  // transaction fields; the burst is brought to the internal width here.
  // ---------------------------------------------------------------------------
  logic                  in_v_r;
  req_e_t                req_r;
  logic [TAG_W-1:0]      tag_r;
  logic [BURST_BITS-1:0] burst_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r   <= req_e_t'(in_req_type);
      tag_r   <= in_task_tag;
      burst_r <= BURST_BITS'(in_burst_length);
    end
  end

  // ---------------------------------------------------------------------------
  // Quantum register. A quantum of zero behaves as one.
  // ---------------------------------------------------------------------------
  logic [SLICE_W-1:0] slice_len_r;
  logic [SLICE_W-1:0] quantum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_len_r <= SLICE_RESET;
    end else if (cfg_we) begin
      slice_len_r <= cfg_wdata;
    end
  end

  assign quantum = (slice_len_r == '0) ? SLICE_MIN : slice_len_r;

  // ---------------------------------------------------------------------------
  // Scheduler state: the running task, its slice count, and the task that was
  // preempted on the previous tick and still has to go back into the ring.
  // ---------------------------------------------------------------------------
  logic               cur_v_r,     cur_v_nxt;
  logic [ENTRY_W-1:0] cur_entry_r, cur_entry_nxt;
  logic [SLICE_W-1:0] slice_r,     slice_nxt;
  logic               pend_v_r,    pend_v_nxt;
  logic [ENTRY_W-1:0] pend_entry_r, pend_entry_nxt;

  ring_ctrl_t         ring_ctrl;
  ring_stat_t         ring_stat;
  logic [ENTRY_W-1:0] ring_push_data;
  logic [ENTRY_W-1:0] ring_pop_data;
  logic [CNT_W-1:0]   ring_count;
  logic [CNT_W-1:0]   ring_count_nxt;

  rrtss_ring #(
    .DEPTH   (RING_DEPTH),
    .ENTRY_W (ENTRY_W),
    .CNT_W   (CNT_W),
    .IDX_W   (IDX_W)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ring_ctrl),
    .push_data (ring_push_data),
    .pop_data  (ring_pop_data),
    .stat      (ring_stat),
    .count     (ring_count),
    .count_nxt (ring_count_nxt)
  );

  // Occupancy counts the queued, running and preempted tasks together; an
  // arrival with a nonzero burst is refused once that total fills the ring.
  logic [OCC_W-1:0] occupied;
  assign occupied = OCC_W'(ring_count) + OCC_W'(cur_v_r) + OCC_W'(pend_v_r);

  // Working values for the task that runs on a tick.
  logic [ENTRY_W-1:0]    run_entry;
  logic [SLICE_W-1:0]    run_slice;
  logic [BURST_BITS-1:0] run_rem;
  logic [TAG_W-1:0]      run_tag;
  logic [ENTRY_W-1:0]    run_entry_new;

  assign run_entry     = cur_v_r ? cur_entry_r : ring_pop_data;
  assign run_slice     = (cur_v_r ? slice_r : '0) + 1'b1;
  assign run_rem       = run_entry[BURST_BITS-1:0] - 1'b1;
  assign run_tag       = run_entry[ENTRY_W-1:BURST_BITS];
  assign run_entry_new = {run_tag, run_rem};

  // Result values before the output register.
  logic                  res_accepted;
  logic                  res_busy;
  logic [TAG_W-1:0]      res_tag;
  logic [BURST_BITS-1:0] res_rem;
  logic                  res_done;
  logic                  res_send;

  always_comb begin
    ring_ctrl      = '0;
    ring_push_data = pend_entry_r;
    cur_v_nxt      = cur_v_r;
    cur_entry_nxt  = cur_entry_r;
    slice_nxt      = slice_r;
    pend_v_nxt     = pend_v_r;
    pend_entry_nxt = pend_entry_r;
    res_accepted   = 1'b0;
    res_busy       = 1'b0;
    res_tag        = '0;
    res_rem        = '0;
    res_done       = 1'b0;
    res_send       = 1'b0;

    if (in_v_r) begin
      case (req_r)
        REQ_ARRIVAL: begin
          res_tag = tag_r;
          if (burst_r == '0) begin
            // A zero burst completes on arrival and never enters the ring.
            res_accepted = 1'b1;
            res_done     = 1'b1;
          end else if (occupied < OCC_W'(RING_DEPTH)) begin
            ring_ctrl.push = 1'b1;
            ring_push_data = {tag_r, burst_r};
            res_accepted   = 1'b1;
          end
        end
        REQ_TICK: begin
          // The preempted task goes in behind any arrivals queued since; an
          // idle processor then takes the head, which may be that same task.
          ring_ctrl.push = pend_v_r;
          ring_push_data = pend_entry_r;
          pend_v_nxt     = 1'b0;
          ring_ctrl.pop  = !cur_v_r;
          if (cur_v_r || ring_stat.pop_ok) begin
            res_busy      = 1'b1;
            res_tag       = run_tag;
            res_rem       = run_rem;
            cur_entry_nxt = run_entry_new;
            if (run_rem == '0) begin
              res_done  = 1'b1;
              cur_v_nxt = 1'b0;
              slice_nxt = '0;
            end else if (run_slice >= quantum) begin
              res_send       = 1'b1;
              pend_v_nxt     = 1'b1;
              pend_entry_nxt = run_entry_new;
              cur_v_nxt      = 1'b0;
              slice_nxt      = '0;
            end else begin
              cur_v_nxt = 1'b1;
              slice_nxt = run_slice;
            end
          end
        end
        default: begin
          res_tag = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r      <= 1'b0;
      cur_entry_r  <= '0;
      slice_r      <= '0;
      pend_v_r     <= 1'b0;
      pend_entry_r <= '0;
    end else begin
      cur_v_r      <= cur_v_nxt;
      cur_entry_r  <= cur_entry_nxt;
      slice_r      <= slice_nxt;
      pend_v_r     <= pend_v_nxt;
      pend_entry_r <= pend_entry_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. The strobe lasts one cycle per transaction.
  // ---------------------------------------------------------------------------
  logic                 out_valid_r;
  logic                 out_accepted_r;
  logic                 out_busy_r;
  logic [TAG_W-1:0]     out_tag_r;
  logic [OUT_REM_W-1:0] out_rem_r;
  logic                 out_done_r;
  logic                 out_send_r;
  logic [CNT_W-1:0]     out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v_r) begin
      out_accepted_r <= res_accepted;
      out_busy_r     <= res_busy;
      out_tag_r      <= res_tag;
      out_rem_r      <= OUT_REM_W'(res_rem);
      out_done_r     <= res_done;
      out_send_r     <= res_send;
      out_count_r    <= ring_count_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_arrival_accepted = out_accepted_r;
  assign out_cpu_busy         = out_busy_r;
  assign out_run_tag          = out_tag_r;
  assign out_run_remaining    = out_rem_r;
  assign out_task_done        = out_done_r;
  assign out_slice_end        = out_send_r;
  assign out_queued_count     = out_count_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A task cannot both finish and be preempted on the same tick.
  `RRTSS_ASSERT_IMP(a_done_xor_send, out_valid_r, !(out_done_r && out_send_r))
  // Every accepted transaction yields exactly one result after the input and result registers.
  `RRTSS_ASSERT_IMP(a_result_follows, start && !busy, ##2 out_valid)
  // A preempted task waiting for requeue means the processor is idle.
  `RRTSS_ASSERT_ALWAYS(a_cur_pend_excl, !(cur_v_r && pend_v_r))
  // Queued, running and preempted tasks never exceed the ring capacity.
  `RRTSS_ASSERT_ALWAYS(a_occupancy, occupied <= OCC_W'(RING_DEPTH))
  // A tick that finds the CPU busy never reports an accepted arrival.
  `RRTSS_ASSERT_IMP(a_tick_no_accept, out_valid_r && out_busy_r, !out_accepted_r)

endmodule

`default_nettype wire

/* tb/round_robin_sched_checker.sv */
module round_robin_sched_checker
  import rrtss_pkg::*;
#(
  parameter int RING_DEPTH = 16,
  parameter int QCNT_W     = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic                 in_req_type,
  input  wire logic [TAG_W-1:0]     in_task_tag,
  input  wire logic [IN_REM_W-1:0]  in_burst_length,
  input  wire logic                 cfg_we,
  input  wire logic [SLICE_W-1:0]   cfg_wdata,
  input  wire logic                 out_valid,
  input  wire logic                 out_arrival_accepted,
  input  wire logic                 out_cpu_busy,
  input  wire logic [TAG_W-1:0]     out_run_tag,
  input  wire logic [OUT_REM_W-1:0] out_run_remaining,
  input  wire logic                 out_task_done,
  input  wire logic                 out_slice_end,
  input  wire logic [QCNT_W-1:0]    out_queued_count,
  output int                        mismatches,
  output int                        reports_awaited
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [IN_REM_W-1:0] remaining;
  } task_slot_t;

  typedef struct packed {
    logic                 accepted;
    logic                 cpu_busy;
    logic [TAG_W-1:0]     tag;
    logic [OUT_REM_W-1:0] remaining;
    logic                 done;
    logic                 slice_end;
    logic [QCNT_W-1:0]    queued;
  } sched_report_t;

  // Shadow copy of the scheduler state.
  task_slot_t          ready_slots [RING_DEPTH];
  int unsigned         head_idx;
  int unsigned         tail_idx;
  int unsigned         ring_fill;
  logic                running;
  task_slot_t          running_task;
  logic [SLICE_W-1:0]  slice_used;
  logic                requeue_due;
  task_slot_t          requeue_task;
  logic [SLICE_W-1:0]  quantum;

  sched_report_t       expected_reports [$];

  function automatic void ring_insert(task_slot_t slot);
    if (ring_fill < RING_DEPTH) begin
      ready_slots[tail_idx] = slot;
      tail_idx = (tail_idx + 1) % RING_DEPTH;
      ring_fill++;
    end
  endfunction

  function automatic sched_report_t schedule_item(req_e_t req, logic [TAG_W-1:0] tag,
                                                  logic [IN_REM_W-1:0] burst);
    sched_report_t      r;
    logic [SLICE_W-1:0] limit;
    int unsigned        occupied;
    r = '0;
    if (req == REQ_ARRIVAL) begin
      occupied = ring_fill + int'(running) + int'(requeue_due);
      r.tag = tag;
      if (burst == '0) begin
        r.accepted = 1'b1;
        r.done     = 1'b1;
      end else if (occupied < RING_DEPTH) begin
        ring_insert('{tag: tag, remaining: burst});
        r.accepted = 1'b1;
      end
    end else begin
      // The task preempted last tick goes in behind any arrivals since then.
      if (requeue_due) begin
        ring_insert(requeue_task);
        requeue_due = 1'b0;
      end
      if (!running && ring_fill > 0) begin
        running_task = ready_slots[head_idx];
        head_idx     = (head_idx + 1) % RING_DEPTH;
        ring_fill--;
        running      = 1'b1;
        slice_used   = '0;
      end
      if (running) begin
        limit = (quantum == '0) ? SLICE_MIN : quantum;
        running_task.remaining = running_task.remaining - 1'b1;
        slice_used  = slice_used + 1'b1;
        r.cpu_busy  = 1'b1;
        r.tag       = running_task.tag;
        r.remaining = running_task.remaining;
        if (running_task.remaining == '0) begin
          r.done     = 1'b1;
          running    = 1'b0;
          slice_used = '0;
        end else if (slice_used >= limit) begin
          r.slice_end  = 1'b1;
          requeue_task = running_task;
          requeue_due  = 1'b1;
          running      = 1'b0;
          slice_used   = '0;
        end
      end
    end
    r.queued = QCNT_W'(ring_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    sched_report_t got;
    sched_report_t want;
    if (!rst_n) begin
      head_idx     = 0;
      tail_idx     = 0;
      ring_fill    = 0;
      running      = 1'b0;
      running_task = '0;
      slice_used   = '0;
      requeue_due  = 1'b0;
      requeue_task = '0;
      quantum      = SLICE_RESET;
      expected_reports.delete();
    end else begin
      if (out_valid) begin
        got = '{accepted: out_arrival_accepted, cpu_busy: out_cpu_busy, tag: out_run_tag,
                remaining: out_run_remaining, done: out_task_done,
                slice_end: out_slice_end, queued: out_queued_count};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: acc=%0d busy=%0d tag=%0d rem=%0d",
                     $time, got.accepted, got.cpu_busy, got.tag, got.remaining);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: expected acc=%0d busy=%0d tag=%0d rem=%0d done=%0d send=%0d q=%0d",
                       $time, want.accepted, want.cpu_busy, want.tag, want.remaining,
                       want.done, want.slice_end, want.queued);
              $display("%0t:   actual acc=%0d busy=%0d tag=%0d rem=%0d done=%0d send=%0d q=%0d",
                       $time, got.accepted, got.cpu_busy, got.tag, got.remaining,
                       got.done, got.slice_end, got.queued);
            end
          end
        end
      end
      if (cfg_we)
        quantum = cfg_wdata;
      if (start && !busy)
        expected_reports.push_back(schedule_item(req_e_t'(in_req_type), in_task_tag,
                                                 in_burst_length));
    end
    reports_awaited <= expected_reports.size();
  end

endmodule

/* tb/tb_round_robin_time_slice_scheduler_core.sv */
module tb_round_robin_time_slice_scheduler_core;
  import rrtss_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int BURST_BITS  = 16;
  localparam int QCNT_W      = $clog2(RING_DEPTH + 1);
  // Margin waited after the block has reported every transaction it took.
  localparam int DRAIN_WAIT  = 4;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 243;
  // The limit leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 200000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_req_type;
  logic [TAG_W-1:0]     in_task_tag;
  logic [IN_REM_W-1:0]  in_burst_length;
  logic                 cfg_we;
  logic [SLICE_W-1:0]   cfg_wdata;
  logic                 out_valid;
  logic                 out_arrival_accepted;
  logic                 out_cpu_busy;
  logic [TAG_W-1:0]     out_run_tag;
  logic [OUT_REM_W-1:0] out_run_remaining;
  logic                 out_task_done;
  logic                 out_slice_end;
  logic [QCNT_W-1:0]    out_queued_count;

  int                   mismatches;
  int                   reports_awaited;
  int                   cycle_count;

  round_robin_time_slice_scheduler_core #(
    .RING_DEPTH (RING_DEPTH),
    .BURST_BITS (BURST_BITS)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_task_tag          (in_task_tag),
    .in_burst_length      (in_burst_length),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_arrival_accepted (out_arrival_accepted),
    .out_cpu_busy         (out_cpu_busy),
    .out_run_tag          (out_run_tag),
    .out_run_remaining    (out_run_remaining),
    .out_task_done        (out_task_done),
    .out_slice_end        (out_slice_end),
    .out_queued_count     (out_queued_count)
  );

  round_robin_sched_checker #(
    .RING_DEPTH (RING_DEPTH),
    .QCNT_W     (QCNT_W)
  ) checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_task_tag          (in_task_tag),
    .in_burst_length      (in_burst_length),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_arrival_accepted (out_arrival_accepted),
    .out_cpu_busy         (out_cpu_busy),
    .out_run_tag          (out_run_tag),
    .out_run_remaining    (out_run_remaining),
    .out_task_done        (out_task_done),
    .out_slice_end        (out_slice_end),
    .out_queued_count     (out_queued_count),
    .mismatches           (mismatches),
    .reports_awaited      (reports_awaited)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Presents one transaction and holds it until the block takes it. Start is left
  // high on return, so that back-to-back transactions keep it asserted; the caller
  // lowers it only when the sender is to go quiet.
  task automatic issue_request(req_e_t req, logic [TAG_W-1:0] tag,
                               logic [IN_REM_W-1:0] burst);
    in_req_type     <= req;
    in_task_tag     <= tag;
    in_burst_length <= burst;
    start           <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Lets every outstanding result come back, then waits out a margin. The first edge is needed
  // because the checker's count is registered and shows the last transaction in the cycle after.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (reports_awaited != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    int unsigned        pick;
    logic [IN_REM_W-1:0] burst;
    int                 tick_pct [PHASES];
    int                 gap_pct  [PHASES];
    logic [SLICE_W-1:0] quanta   [PHASES];

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_req_type     <= REQ_ARRIVAL;
    in_task_tag     <= '0;
    in_burst_length <= '0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;

    // Each phase pairs a quantum with a mix of ticks and arrivals. Arrival-heavy mixes
    // fill the ring and provoke refusals; tick-heavy ones drain it. The first phase keeps
    // the quantum from reset, and the last has no idling at all.
    quanta   = '{SLICE_RESET, 8'd1, 8'd255, 8'd0, 8'd2, 8'($urandom_range(3, 16)), 8'd3};
    tick_pct = '{30, 50, 60, 25, 75, 45, 50};
    gap_pct  = '{25, 0, 40, 15, 30, 20, 0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed opening under the reset quantum of four ticks. A tick on an empty
    // scheduler finds the CPU idle; its tag and burst fields must be ignored.
    issue_request(REQ_TICK, 4'hF, 16'hFFFF);
    // A zero burst completes at once and never enters the ring.
    issue_request(REQ_ARRIVAL, 4'h0, 16'h0000);
    // The longest burst stays resident for the rest of the run.
    issue_request(REQ_ARRIVAL, 4'hF, 16'hFFFF);
    issue_request(REQ_ARRIVAL, 4'h3, 16'h0001);
    issue_request(REQ_ARRIVAL, 4'hC, 16'h0005);
    // Enough ticks to see a slice end, the requeue behind waiting tasks, a one-tick task
    // finishing and a second slice end.
    repeat (10) issue_request(REQ_TICK, 4'h0, 16'h0000);
    issue_request(REQ_ARRIVAL, 4'h7, 16'h0000);
    repeat (2) issue_request(REQ_TICK, 4'h0, 16'h0000);

    for (int ph = 0; ph < PHASES; ph++) begin
      // The quantum is only rewritten once the block has nothing in flight.
      if (ph != 0) begin
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= quanta[ph];
        @(posedge clk);
        cfg_we    <= 1'b0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < gap_pct[ph]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        // Bursts are mostly short so that tasks finish and slots come free; a rare
        // full-width burst exercises every bit but then stays resident.
        pick = $urandom_range(0, 399);
        if (pick == 0)
          burst = IN_REM_W'($urandom);
        else if (pick < 40)
          burst = '0;
        else if (pick < 160)
          burst = IN_REM_W'($urandom_range(1, 3));
        else if (pick < 370)
          burst = IN_REM_W'($urandom_range(1, 16));
        else
          burst = IN_REM_W'($urandom_range(17, 64));
        if ($urandom_range(0, 99) < tick_pct[ph])
          issue_request(REQ_TICK, TAG_W'($urandom), IN_REM_W'($urandom));
        else
          issue_request(REQ_ARRIVAL, TAG_W'($urandom), burst);
      end
    end

    drain_results();
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* round_robin_time_slice_scheduler_core.f */
+incdir+src
src/rrtss_pkg.sv
src/rrtss_ring.sv
src/round_robin_time_slice_scheduler_core.sv
tb/round_robin_sched_checker.sv
tb/tb_round_robin_time_slice_scheduler_core.sv
